### hdl/cpra_pkg.sv
// Shared constants, types and status codes of the contiguous page run allocator.
`default_nettype none

package cpra_pkg;

    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int TABLE_COUNT       = 1024;
    localparam int FIRST_TABLE       = 8;
    localparam int PAGE_BYTES        = 4096;
    localparam int BITMAP_WORD       = 64;

    localparam int TOTAL_PAGES = TABLE_COUNT * ENTRIES_PER_TABLE;
    localparam int WORD_COUNT  = (TOTAL_PAGES + BITMAP_WORD - 1) / BITMAP_WORD;
    localparam int START_PAGE  = FIRST_TABLE * ENTRIES_PER_TABLE;
    localparam int START_WORD  = START_PAGE / BITMAP_WORD;

    localparam int BYTES_W    = 32;
    localparam int VA_W       = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(TOTAL_PAGES);
    localparam int CNT_W      = 21;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int BIT_W      = $clog2(BITMAP_WORD);
    localparam int CHUNK      = 8;
    localparam int CHUNK_SH   = $clog2(CHUNK);
    localparam int CHUNKS     = BITMAP_WORD / CHUNK;
    localparam int CHUNK_IW   = $clog2(CHUNKS);

    localparam int REG_IDX_W = 1;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_RESERVED_PAGES = '0;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_SIZE  = 2'd1,
        ST_OVER_QUOTA = 2'd2,
        ST_NO_RUN     = 2'd3
    } status_t;

endpackage

`default_nettype wire

### hdl/cpra_if.sv
// Request and response channel interfaces of the allocator.
`default_nettype none

interface cpra_req_if;
    logic                         valid;
    logic                         ready;
    logic [cpra_pkg::BYTES_W-1:0] request_bytes;

    modport source (output valid, output request_bytes, input ready);
    modport sink   (input valid, input request_bytes, output ready);
endinterface

interface cpra_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [cpra_pkg::VA_W-1:0] virtual_address;
    logic [1:0]                status;

    modport source (output valid, output virtual_address, output status, input ready);
    modport sink   (input valid, input virtual_address, input status, output ready);
endinterface

`default_nettype wire

### hdl/contiguous_page_run_allocator_core.sv
// First-fit contiguous page run allocator over a used-page bitmap memory.
//
//   channel | dir | handshake                  | payload
//   req     | in  | valid/ready                | request_bytes[31:0]
//   rsp     | out | valid/ready                | virtual_address[31:0], status[1:0]
//   cfg     | in  | APB psel/penable/pwrite    | reserved_pages at byte address 0
//
// After reset a clearing pass zeroes all 16384 bitmap words, one word a cycle, with req.ready low.
// A request passes the size and quota check in S_IDLE, S_QUOTA and S_DECIDE; then the scan reads
// bitmap words from the memory's read port: S_EVAL settles an all-free or all-used word whole, and
// a mixed word goes on to S_CHUNK, eight pages per chunk. S_MARK_SETUP and S_MARK then mark the
// run word by word, and S_DONE loads the result; req.ready is high only in idle.
// The response register holds a result until taken, while the next request is already accepted.
`default_nettype none

module contiguous_page_run_allocator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cpra_req_if.sink                           req,
    cpra_rsp_if.source                         rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cpra_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [cpra_pkg::DATA_W-1:0]   pwdata,
    output logic      [cpra_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QUOTA,
        S_DECIDE,
        S_EVAL,
        S_CHUNK,
        S_MARK_SETUP,
        S_MARK,
        S_DONE
    } state_t;

    localparam int CNT_W     = cpra_pkg::CNT_W;
    localparam int PAGE_W    = cpra_pkg::PAGE_W;
    localparam int WORD_AW   = cpra_pkg::WORD_AW;
    localparam int BIT_W     = cpra_pkg::BIT_W;
    localparam int BW        = cpra_pkg::BITMAP_WORD;
    localparam int CIW       = cpra_pkg::CHUNK_IW;
    localparam int CSH       = cpra_pkg::CHUNK_SH;
    localparam int PSH       = cpra_pkg::PAGE_SHIFT;
    localparam int REG_SEL_W = cpra_pkg::REG_IDX_W;

    localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(cpra_pkg::WORD_COUNT - 1);
    localparam logic [WORD_AW-1:0] FIRST_WORD = WORD_AW'(cpra_pkg::START_WORD);
    localparam logic [CNT_W-1:0]   FIRST_PAGE = CNT_W'(cpra_pkg::START_PAGE);
    localparam logic [CNT_W:0]     TOTAL_EXT  = (CNT_W+1)'(cpra_pkg::TOTAL_PAGES);
    localparam logic [CIW-1:0]     LAST_CHUNK = CIW'(cpra_pkg::CHUNKS - 1);

    state_t                state_reg, state_next;
    logic [WORD_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]      pages_reg, pages_next;
    logic                  zero_reg, zero_next;
    logic [CNT_W-1:0]      quota_reg, quota_next;
    logic [CNT_W-1:0]      pages_in_use_reg, pages_in_use_next;
    logic [CNT_W-1:0]      reserved_pages_reg, reserved_pages_next;
    logic [CNT_W-1:0]      run_len_reg, run_len_next;
    logic [CNT_W-1:0]      run_start_reg, run_start_next;
    logic [WORD_AW-1:0]    scan_word_reg, scan_word_next;
    logic [CIW-1:0]        chunk_reg, chunk_next;
    logic [PAGE_W-1:0]     end_page_reg, end_page_next;
    logic [WORD_AW-1:0]    mark_word_reg, mark_word_next;
    cpra_pkg::status_t     res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [cpra_pkg::VA_W-1:0] out_va_reg, out_va_next;
    cpra_pkg::status_t     out_status_reg, out_status_next;

    logic [BW-1:0]         bitmap_mem [cpra_pkg::WORD_COUNT];
    logic [BW-1:0]         rd_data_reg;
    logic [WORD_AW-1:0]    rd_addr;
    logic                  wr_en;
    logic [WORD_AW-1:0]    wr_addr;
    logic [BW-1:0]         wr_data;

    logic [CNT_W-1:0]      chunk_len;
    logic [CNT_W-1:0]      chunk_start;
    logic                  chunk_hit;

    logic [BIT_W-1:0]      mask_lo;
    logic [BIT_W-1:0]      mask_hi;
    logic [BW-1:0]         mark_mask;

    logic                  cfg_write;
    logic [REG_SEL_W-1:0]  cfg_sel;

    assign cfg_sel   = paddr[cpra_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (cfg_sel == cpra_pkg::REG_RESERVED_PAGES)
        begin
            prdata = cpra_pkg::DATA_W'(reserved_pages_reg);
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.virtual_address = out_va_reg;
    assign rsp.status          = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    always_comb
    begin
        logic [CNT_W-1:0]  rl;
        logic [CNT_W-1:0]  rs;
        logic              hit;
        logic [PAGE_W-1:0] p;
        rl  = run_len_reg;
        rs  = run_start_reg;
        hit = 1'b0;
        p   = '0;
        for (int i = 0; i < cpra_pkg::CHUNK; i++)
        begin
            p = {scan_word_reg, chunk_reg, CSH'(i)};
            if (!hit)
            begin
                if (rd_data_reg[{chunk_reg, CSH'(i)}])
                begin
                    rl = '0;
                    rs = CNT_W'(p) + CNT_W'(1);
                end
                else
                begin
                    rl = rl + CNT_W'(1);
                    if (rl == pages_reg)
                    begin
                        hit = 1'b1;
                    end
                end
            end
        end
        chunk_len   = rl;
        chunk_start = rs;
        chunk_hit   = hit;
    end

    always_comb
    begin
        mask_lo = '0;
        mask_hi = BIT_W'(BW - 1);
        if (mark_word_reg == run_start_reg[PAGE_W-1:BIT_W])
        begin
            mask_lo = run_start_reg[BIT_W-1:0];
        end
        if (mark_word_reg == end_page_reg[PAGE_W-1:BIT_W])
        begin
            mask_hi = end_page_reg[BIT_W-1:0];
        end
        mark_mask = ({BW{1'b1}} << mask_lo) & ({BW{1'b1}} >> (BIT_W'(BW - 1) - mask_hi));
    end

    always_comb
    begin
        logic [CNT_W:0] charged;
        logic           load_out;
        charged             = {1'b0, pages_in_use_reg} + {1'b0, reserved_pages_reg};
        load_out            = 1'b0;

        state_next          = state_reg;
        clr_addr_next       = clr_addr_reg;
        pages_next          = pages_reg;
        zero_next           = zero_reg;
        quota_next          = quota_reg;
        pages_in_use_next   = pages_in_use_reg;
        reserved_pages_next = reserved_pages_reg;
        run_len_next        = run_len_reg;
        run_start_next      = run_start_reg;
        scan_word_next      = scan_word_reg;
        chunk_next          = chunk_reg;
        end_page_next       = end_page_reg;
        mark_word_next      = mark_word_reg;
        res_status_next     = res_status_reg;
        out_va_next         = out_va_reg;
        out_status_next     = out_status_reg;

        rd_addr = scan_word_reg;
        wr_en   = 1'b0;
        wr_addr = mark_word_reg;
        wr_data = rd_data_reg | mark_mask;

        if (cfg_write && cfg_sel == cpra_pkg::REG_RESERVED_PAGES)
        begin
            reserved_pages_next = pwdata[CNT_W-1:0];
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + WORD_AW'(1);
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    zero_next  = (req.request_bytes == '0);
                    pages_next = CNT_W'(req.request_bytes[cpra_pkg::BYTES_W-1:PSH])
                               + CNT_W'(|req.request_bytes[PSH-1:0]);
                    state_next = S_QUOTA;
                end
            end
            S_QUOTA:
            begin
                quota_next = (charged >= TOTAL_EXT) ? '0 : CNT_W'(TOTAL_EXT - charged);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (zero_reg)
                begin
                    res_status_next = cpra_pkg::ST_ZERO_SIZE;
                    state_next      = S_DONE;
                end
                else if (pages_reg > quota_reg)
                begin
                    res_status_next = cpra_pkg::ST_OVER_QUOTA;
                    state_next      = S_DONE;
                end
                else
                begin
                    pages_in_use_next = pages_in_use_reg + pages_reg;
                    run_len_next      = '0;
                    run_start_next    = FIRST_PAGE;
                    scan_word_next    = FIRST_WORD;
                    rd_addr           = FIRST_WORD;
                    state_next        = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (rd_data_reg == '0)
                begin
                    if ((CNT_W+1)'(run_len_reg) + (CNT_W+1)'(BW) >= (CNT_W+1)'(pages_reg))
                    begin
                        state_next = S_MARK_SETUP;
                    end
                    else
                    begin
                        run_len_next = run_len_reg + CNT_W'(BW);
                        if (scan_word_reg == LAST_WORD)
                        begin
                            res_status_next = cpra_pkg::ST_NO_RUN;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            scan_word_next = scan_word_reg + WORD_AW'(1);
                            rd_addr        = scan_word_reg + WORD_AW'(1);
                        end
                    end
                end
                else if (rd_data_reg == {BW{1'b1}})
                begin
                    run_len_next   = '0;
                    run_start_next = CNT_W'({scan_word_reg, {BIT_W{1'b0}}}) + CNT_W'(BW);
                    if (scan_word_reg == LAST_WORD)
                    begin
                        res_status_next = cpra_pkg::ST_NO_RUN;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        scan_word_next = scan_word_reg + WORD_AW'(1);
                        rd_addr        = scan_word_reg + WORD_AW'(1);
                    end
                end
                else
                begin
                    chunk_next = '0;
                    state_next = S_CHUNK;
                end
            end
            S_CHUNK:
            begin
                run_len_next   = chunk_len;
                run_start_next = chunk_start;
                if (chunk_hit)
                begin
                    state_next = S_MARK_SETUP;
                end
                else if (chunk_reg != LAST_CHUNK)
                begin
                    chunk_next = chunk_reg + CIW'(1);
                end
                else if (scan_word_reg == LAST_WORD)
                begin
                    res_status_next = cpra_pkg::ST_NO_RUN;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_word_next = scan_word_reg + WORD_AW'(1);
                    rd_addr        = scan_word_reg + WORD_AW'(1);
                    state_next     = S_EVAL;
                end
            end
            S_MARK_SETUP:
            begin
                end_page_next  = PAGE_W'(run_start_reg + pages_reg - CNT_W'(1));
                mark_word_next = run_start_reg[PAGE_W-1:BIT_W];
                rd_addr        = run_start_reg[PAGE_W-1:BIT_W];
                state_next     = S_MARK;
            end
            S_MARK:
            begin
                wr_en = 1'b1;
                if (mark_word_reg == end_page_reg[PAGE_W-1:BIT_W])
                begin
                    res_status_next = cpra_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    mark_word_next = mark_word_reg + WORD_AW'(1);
                    rd_addr        = mark_word_reg + WORD_AW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out        = 1'b1;
                    out_status_next = res_status_reg;
                    out_va_next     = '0;
                    if (res_status_reg == cpra_pkg::ST_OK)
                    begin
                        out_va_next = {run_start_reg[PAGE_W-1:0], {PSH{1'b0}}};
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            clr_addr_reg       <= '0;
            pages_in_use_reg   <= '0;
            reserved_pages_reg <= '0;
            out_valid_reg      <= 1'b0;
            zero_reg           <= 1'b0;
            res_status_reg     <= cpra_pkg::ST_OK;
            out_status_reg     <= cpra_pkg::ST_OK;
            pages_reg          <= '0;
            quota_reg          <= '0;
            run_len_reg        <= '0;
            run_start_reg      <= '0;
            scan_word_reg      <= '0;
            chunk_reg          <= '0;
            end_page_reg       <= '0;
            mark_word_reg      <= '0;
            out_va_reg         <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            clr_addr_reg       <= clr_addr_next;
            pages_in_use_reg   <= pages_in_use_next;
            reserved_pages_reg <= reserved_pages_next;
            out_valid_reg      <= out_valid_next;
            zero_reg           <= zero_next;
            res_status_reg     <= res_status_next;
            out_status_reg     <= out_status_next;
            pages_reg          <= pages_next;
            quota_reg          <= quota_next;
            run_len_reg        <= run_len_next;
            run_start_reg      <= run_start_next;
            scan_word_reg      <= scan_word_next;
            chunk_reg          <= chunk_next;
            end_page_reg       <= end_page_next;
            mark_word_reg      <= mark_word_next;
            out_va_reg         <= out_va_next;
        end
    end

`ifndef SYNTHESIS
    a_ok_addr_above_start: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == cpra_pkg::ST_OK)
        |-> (rsp.virtual_address[cpra_pkg::VA_W-1:PSH] >= PAGE_W'(cpra_pkg::START_PAGE)))
        else $error("allocated address below first table");

    a_error_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != cpra_pkg::ST_OK) |-> (rsp.virtual_address == '0))
        else $error("failed allocation carries an address");

    a_run_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL || state_reg == S_CHUNK) |-> (run_len_reg < pages_reg))
        else $error("scan run length reached request without a hit");

    a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_in_use_reg <= CNT_W'(cpra_pkg::TOTAL_PAGES))
        else $error("pages in use exceed total pages");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK)
        |-> (mark_word_reg >= run_start_reg[PAGE_W-1:BIT_W]
             && mark_word_reg <= end_page_reg[PAGE_W-1:BIT_W]))
        else $error("mark word outside the run");
`endif

endmodule

`default_nettype wire
